// File: sv/lcd_frame_segment_decoder_macros.svh
// Assertion macros shared by the frame decoder.
`ifndef LCD_FRAME_SEGMENT_DECODER_MACROS_SVH
`define LCD_FRAME_SEGMENT_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LFSD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcd_frame_segment_decoder: check failed");

// Next-cycle implication, checked outside reset.
`define LFSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcd_frame_segment_decoder: check failed");

`endif

// File: sv/lfsd_pkg.sv
package lfsd_pkg;

  localparam int FRAME_BYTES = 8;
  localparam int IDX_W       = $clog2(FRAME_BYTES);

  typedef logic [3:0]        nibble_t;
  typedef logic [4:0]        count_t;
  typedef logic [3:0]        digit_t;
  typedef logic signed [4:0] exp_t;
  typedef logic [2:0]        point_t;

  localparam nibble_t FIRST_POSITION = 4'd1;
  localparam nibble_t LAST_POSITION  = 4'd14;
  localparam count_t  COUNT_MAX      = 5'd31;
  localparam logic [7:0] PREFIX_MASK = 8'hEA;

  localparam digit_t DIGIT_L       = 4'd10;
  localparam digit_t DIGIT_BLANK   = 4'd11;
  localparam digit_t DIGIT_UNKNOWN = 4'd12;

  localparam exp_t EXP_NANO  = -5'sd9;
  localparam exp_t EXP_MICRO = -5'sd6;
  localparam exp_t EXP_MILLI = -5'sd3;
  localparam exp_t EXP_NONE  = 5'sd0;
  localparam exp_t EXP_KILO  = 5'sd3;
  localparam exp_t EXP_MEGA  = 5'sd6;

  // Maps a seven-segment pattern to its digit code.
  function automatic digit_t seg_to_digit(input logic [6:0] pattern);
    digit_t code;
    unique case (pattern)
      7'h7D:   code = 4'd0;
      7'h05:   code = 4'd1;
      7'h5B:   code = 4'd2;
      7'h1F:   code = 4'd3;
      7'h27:   code = 4'd4;
      7'h3E:   code = 4'd5;
      7'h7E:   code = 4'd6;
      7'h15:   code = 4'd7;
      7'h7F:   code = 4'd8;
      7'h3F:   code = 4'd9;
      7'h68:   code = DIGIT_L;
      7'h00:   code = DIGIT_BLANK;
      default: code = DIGIT_UNKNOWN;
    endcase
    return code;
  endfunction

endpackage

// File: sv/lfsd_ifs.sv
interface lfsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface lfsd_out_if;
  logic                 valid;
  logic                 ready;
  logic                 negative;
  lfsd_pkg::digit_t     digit_first;
  lfsd_pkg::digit_t     digit_second;
  lfsd_pkg::digit_t     digit_third;
  lfsd_pkg::digit_t     digit_fourth;
  lfsd_pkg::point_t     point_mask;
  lfsd_pkg::exp_t       exponent;
  logic                 prefix_conflict;

  modport source (output valid, output negative, output digit_first, output digit_second,
                  output digit_third, output digit_fourth, output point_mask,
                  output exponent, output prefix_conflict, input ready);
  modport sink (input valid, input negative, input digit_first, input digit_second,
                input digit_third, input digit_fourth, input point_mask,
                input exponent, input prefix_conflict, output ready);
endinterface

// File: sv/lcd_frame_segment_decoder.sv
// Decodes the position-tagged nibble stream of a meter display link. Each word is
// captured in an input register, and a new word can be accepted each cycle unless
// the input stalls: the frame state (eight frame bytes, position counter, error
// flag) is updated from the input register, and a completed good frame is decoded
// into the output register in the same cycle; a result passes through the input
// register and then the output register. The output register lets the next words
// enter while a result waits; only a frame-closing word can stall the input, behind
// a result that has not yet been taken.
`include "lcd_frame_segment_decoder_macros.svh"

module lcd_frame_segment_decoder (
  input  logic              clk,
  input  logic              rst_n,
  lfsd_in_if.sink           in_link,
  lfsd_out_if.source        out_link
);

  logic                 in_valid_r;
  logic [7:0]           byte_r;
  lfsd_pkg::count_t     cnt_r;
  lfsd_pkg::count_t     cnt_nxt;
  logic                 err_r;
  logic                 err_nxt;
  logic [7:0]           store_r   [lfsd_pkg::FRAME_BYTES];
  logic [7:0]           store_nxt [lfsd_pkg::FRAME_BYTES];

  lfsd_pkg::nibble_t    pos;
  lfsd_pkg::nibble_t    data;
  lfsd_pkg::count_t     cnt_base;
  logic [lfsd_pkg::IDX_W-1:0] idx;
  logic                 hit;
  logic                 produce;
  logic                 consume;
  logic                 out_free;

  logic [7:0]           pfx;
  logic [2:0]           nbits;
  lfsd_pkg::exp_t       exp_nxt;

  logic                 out_valid_r;
  logic                 neg_r;
  lfsd_pkg::digit_t     dig1_r, dig2_r, dig3_r, dig4_r;
  lfsd_pkg::point_t     point_r;
  lfsd_pkg::exp_t       exp_r;
  logic                 conflict_r;

  assign pos  = byte_r[7:4];
  assign data = byte_r[3:0];
  assign idx  = pos[lfsd_pkg::IDX_W:1];

  // Frame state update for the word held in the input register.
  always_comb begin
    store_nxt = store_r;
    if (pos == lfsd_pkg::FIRST_POSITION) begin
      cnt_base     = '0;
      err_nxt      = 1'b0;
      store_nxt[0] = '0;
    end else begin
      cnt_base     = cnt_r;
      err_nxt      = err_r;
    end
    cnt_nxt = (cnt_base == lfsd_pkg::COUNT_MAX) ? lfsd_pkg::COUNT_MAX : cnt_base + 5'd1;
    hit     = (cnt_nxt == {1'b0, pos});
    if (!hit) begin
      err_nxt = 1'b1;
    end else if (pos[0]) begin
      store_nxt[idx] = store_nxt[idx] | {4'h0, data};
    end else begin
      store_nxt[idx] = {data, 4'h0};
    end
  end

  // Unit prefix: exactly one bit selects the exponent.
  always_comb begin
    pfx     = store_nxt[5] & lfsd_pkg::PREFIX_MASK;
    nbits   = 3'($countones(pfx));
    exp_nxt = lfsd_pkg::EXP_NONE;
    if (nbits == 3'd1) begin
      priority if (pfx[7]) exp_nxt = lfsd_pkg::EXP_MICRO;
      else if (pfx[6])     exp_nxt = lfsd_pkg::EXP_NANO;
      else if (pfx[5])     exp_nxt = lfsd_pkg::EXP_KILO;
      else if (pfx[3])     exp_nxt = lfsd_pkg::EXP_MILLI;
      else                 exp_nxt = lfsd_pkg::EXP_MEGA;
    end
  end

  assign produce        = in_valid_r && (pos == lfsd_pkg::LAST_POSITION) && !err_nxt;
  assign out_free       = !out_valid_r || out_link.ready;
  assign consume        = in_valid_r && (!produce || out_free);
  assign in_link.ready  = !in_valid_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      cnt_r       <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < lfsd_pkg::FRAME_BYTES; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      if (in_link.ready) begin
        in_valid_r <= in_link.valid;
      end
      if (consume) begin
        cnt_r   <= cnt_nxt;
        err_r   <= err_nxt;
        store_r <= store_nxt;
      end
      if (produce && consume) begin
        out_valid_r <= 1'b1;
      end else if (out_link.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_link.ready) begin
      byte_r <= in_link.rx_byte;
    end
    if (produce && consume) begin
      neg_r      <= store_nxt[1][7];
      dig1_r     <= lfsd_pkg::seg_to_digit(store_nxt[1][6:0]);
      dig2_r     <= lfsd_pkg::seg_to_digit(store_nxt[2][6:0]);
      dig3_r     <= lfsd_pkg::seg_to_digit(store_nxt[3][6:0]);
      dig4_r     <= lfsd_pkg::seg_to_digit(store_nxt[4][6:0]);
      point_r    <= {store_nxt[4][7], store_nxt[3][7], store_nxt[2][7]};
      exp_r      <= exp_nxt;
      conflict_r <= (nbits > 3'd1);
    end
  end

  assign out_link.valid           = out_valid_r;
  assign out_link.negative        = neg_r;
  assign out_link.digit_first     = dig1_r;
  assign out_link.digit_second    = dig2_r;
  assign out_link.digit_third     = dig3_r;
  assign out_link.digit_fourth    = dig4_r;
  assign out_link.point_mask      = point_r;
  assign out_link.exponent        = exp_r;
  assign out_link.prefix_conflict = conflict_r;

  `LFSD_ASSERT_NEXT(a_result_loaded, produce && consume, out_valid_r)
  `LFSD_ASSERT_NEXT(a_input_held, in_valid_r && !consume, in_valid_r && $stable(byte_r))
  `LFSD_ASSERT_NEXT(a_count_advanced, consume, cnt_r != 5'd0)
  `LFSD_ASSERT_NEXT(a_restart_clears_error,
                    consume && (pos == lfsd_pkg::FIRST_POSITION), !err_r)

endmodule

// File: bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int REPORT_MAX = 10;

  // Seven-segment patterns in digit-code order; the last two are L and blank.
  localparam logic [6:0] SEG_PATTERN [12] = '{
    7'h7D, 7'h05, 7'h5B, 7'h1F, 7'h27, 7'h3E, 7'h7E, 7'h15, 7'h7F, 7'h3F, 7'h68, 7'h00
  };

  localparam logic [7:0] PFX_MICRO = 8'h80;
  localparam logic [7:0] PFX_NANO  = 8'h40;
  localparam logic [7:0] PFX_KILO  = 8'h20;
  localparam logic [7:0] PFX_MILLI = 8'h08;
  localparam logic [7:0] PFX_MEGA  = 8'h02;
  localparam logic [7:0] PFX_CHOICES [6] = '{
    PFX_MICRO, PFX_NANO, PFX_KILO, PFX_MILLI, PFX_MEGA, 8'h00
  };

  typedef enum int {
    FLAW_NONE, FLAW_REPLACE, FLAW_DROP, FLAW_REPEAT, FLAW_TRUNCATE
  } flaw_t;

  typedef logic [7:0][7:0] frame_t;

  typedef struct packed {
    logic             negative;
    lfsd_pkg::digit_t d1;
    lfsd_pkg::digit_t d2;
    lfsd_pkg::digit_t d3;
    lfsd_pkg::digit_t d4;
    lfsd_pkg::point_t points;
    logic [4:0]       expo;
    logic             conflict;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n;

  lfsd_in_if  in_link ();
  lfsd_out_if out_link ();

  lcd_frame_segment_decoder DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_link  (in_link),
    .out_link (out_link)
  );

  always #2 clk = ~clk;

  // Shadow of the decoder's frame state.
  logic [7:0]       shadow_frame [8];
  lfsd_pkg::count_t shadow_count;
  logic             shadow_bad;

  reading_t pending_readings [$];

  int idle_pct;
  int stall_pct;
  int bytes_sent;
  int readings_seen;
  int mismatches;
  int cycles;

  function automatic lfsd_pkg::digit_t digit_of(input logic [6:0] pat);
    lfsd_pkg::digit_t code;
    code = lfsd_pkg::DIGIT_UNKNOWN;
    for (int k = 0; k < 12; k++) begin
      if (SEG_PATTERN[k] == pat) code = lfsd_pkg::digit_t'(k);
    end
    return code;
  endfunction

  // Applies one accepted word to the shadow state and queues the reading it closes.
  task automatic track_display_byte(input logic [7:0] b);
    lfsd_pkg::nibble_t pos;
    lfsd_pkg::nibble_t data;
    logic [2:0]        idx;
    logic [7:0]        pfx;
    reading_t          r;
    pos = b[7:4];
    data = b[3:0];
    if (pos == lfsd_pkg::FIRST_POSITION) begin
      shadow_count = '0;
      shadow_bad = 1'b0;
      shadow_frame[0] = '0;
    end
    if (shadow_count != lfsd_pkg::COUNT_MAX) shadow_count = shadow_count + 5'd1;
    if ({1'b0, pos} != shadow_count) begin
      shadow_bad = 1'b1;
    end else begin
      idx = pos[3:1];
      if (pos[0]) shadow_frame[idx] = shadow_frame[idx] | {4'h0, data};
      else shadow_frame[idx] = {data, 4'h0};
    end
    if (pos == lfsd_pkg::LAST_POSITION && !shadow_bad) begin
      r.negative = shadow_frame[1][7];
      r.d1 = digit_of(shadow_frame[1][6:0]);
      r.d2 = digit_of(shadow_frame[2][6:0]);
      r.d3 = digit_of(shadow_frame[3][6:0]);
      r.d4 = digit_of(shadow_frame[4][6:0]);
      r.points = {shadow_frame[4][7], shadow_frame[3][7], shadow_frame[2][7]};
      pfx = shadow_frame[5] & lfsd_pkg::PREFIX_MASK;
      r.conflict = ($countones(pfx) > 1);
      if ($countones(pfx) != 1) r.expo = lfsd_pkg::EXP_NONE;
      else if (pfx & PFX_MICRO) r.expo = lfsd_pkg::EXP_MICRO;
      else if (pfx & PFX_NANO) r.expo = lfsd_pkg::EXP_NANO;
      else if (pfx & PFX_KILO) r.expo = lfsd_pkg::EXP_KILO;
      else if (pfx & PFX_MILLI) r.expo = lfsd_pkg::EXP_MILLI;
      else r.expo = lfsd_pkg::EXP_MEGA;
      pending_readings.push_back(r);
    end
  endtask

  // Called and returns at a falling edge; valid is left high after the word so
  // that back-to-back words never lower and raise it in the same step.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_link.valid <= 1'b0;
      @(negedge clk);
    end
    in_link.valid <= 1'b1;
    in_link.rx_byte <= b;
    @(posedge clk);
    while (!in_link.ready) @(posedge clk);
    track_display_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input frame_t f, input flaw_t flaw, input int flaw_at,
                            input logic [7:0] alt);
    logic [7:0] b;
    logic [3:0] p4;
    bit         stop;
    stop = 1'b0;
    for (int p = 1; p <= lfsd_pkg::LAST_POSITION && !stop; p++) begin
      p4 = p[3:0];
      b = {p4, p4[0] ? f[p4 >> 1][3:0] : f[p4 >> 1][7:4]};
      if (p == flaw_at && flaw != FLAW_NONE) begin
        case (flaw)
          FLAW_REPLACE: begin
            send_byte(alt);
          end
          FLAW_REPEAT: begin
            send_byte(b);
            send_byte(b);
          end
          FLAW_TRUNCATE: begin
            stop = 1'b1;
          end
          default: begin
          end
        endcase
      end else begin
        send_byte(b);
      end
    end
  endtask

  function automatic frame_t random_frame();
    frame_t     f;
    logic [6:0] pat;
    int         roll;
    f = {$urandom, $urandom};
    for (int k = 1; k <= 4; k++) begin
      if ($urandom_range(7) == 0) pat = 7'($urandom);
      else pat = SEG_PATTERN[$urandom_range(11)];
      f[k] = {1'($urandom_range(1)), pat};
    end
    roll = $urandom_range(9);
    if (roll == 0) begin
      f[5] = 8'($urandom);
    end else if (roll == 1) begin
      f[5] = PFX_CHOICES[$urandom_range(4)] | PFX_CHOICES[$urandom_range(4)]
           | PFX_CHOICES[$urandom_range(4)];
    end else begin
      f[5] = PFX_CHOICES[$urandom_range(5)] | (8'($urandom) & ~lfsd_pkg::PREFIX_MASK);
    end
    return f;
  endfunction

  task automatic set_pacing(input int idle, input int stall);
    idle_pct = idle;
    stall_pct = stall;
  endtask

  task automatic test_extreme_frames();
    frame_t f;
    send_frame('1, FLAW_NONE, 0, 8'h00);
    send_frame('0, FLAW_NONE, 0, 8'h00);
    f = '0;
    f[1] = {1'b1, SEG_PATTERN[lfsd_pkg::DIGIT_L]};
    f[2] = {1'b0, SEG_PATTERN[lfsd_pkg::DIGIT_BLANK]};
    f[3] = {1'b1, SEG_PATTERN[9]};
    f[4] = {1'b0, 7'h01};
    f[5] = PFX_KILO;
    send_frame(f, FLAW_NONE, 0, 8'h00);
  endtask

  // A skipped position poisons the rest of the frame.
  task automatic test_sticky_error();
    send_frame(random_frame(), FLAW_DROP, 3, 8'h00);
  endtask

  // Position 15 can still match right after a good frame; the repeat of 14 cannot.
  task automatic test_past_last_position();
    send_frame(random_frame(), FLAW_NONE, 0, 8'h00);
    send_byte(8'hF3);
    send_byte(8'hE0);
  endtask

  // Enough bad words to run the position counter past its top, including position zero.
  task automatic test_counter_saturation();
    for (int k = 0; k < 40; k++) begin
      case (k % 3)
        0: send_byte(8'h00);
        1: send_byte(8'hEF);
        default: send_byte(8'hF0);
      endcase
    end
    send_frame(random_frame(), FLAW_NONE, 0, 8'h00);
  endtask

  task automatic test_random_traffic(input int n_bytes);
    int   start;
    int   roll;
    flaw_t flaw;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      roll = $urandom_range(99);
      if (roll < 72) begin
        send_frame(random_frame(), FLAW_NONE, 0, 8'h00);
      end else if (roll < 87) begin
        flaw = flaw_t'($urandom_range(FLAW_REPLACE, FLAW_TRUNCATE));
        send_frame(random_frame(), flaw, $urandom_range(1, lfsd_pkg::LAST_POSITION),
                   8'($urandom));
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end
    end
  endtask

  always @(negedge clk) begin
    out_link.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin : check_readings
    reading_t got;
    reading_t want;
    if (rst_n && out_link.valid && out_link.ready) begin
      got.negative = out_link.negative;
      got.d1 = out_link.digit_first;
      got.d2 = out_link.digit_second;
      got.d3 = out_link.digit_third;
      got.d4 = out_link.digit_fourth;
      got.points = out_link.point_mask;
      got.expo = out_link.exponent;
      got.conflict = out_link.prefix_conflict;
      readings_seen++;
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("tb: reading with none pending: neg=%0d digits=%0d,%0d,%0d,%0d dp=%b",
                   got.negative, got.d1, got.d2, got.d3, got.d4, got.points);
      end else begin
        want = pending_readings.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("tb: want neg=%0d digits=%0d,%0d,%0d,%0d dp=%b exp=%0d conflict=%0d",
                     want.negative, want.d1, want.d2, want.d3, want.d4, want.points,
                     $signed(want.expo), want.conflict);
            $display("tb: got  neg=%0d digits=%0d,%0d,%0d,%0d dp=%b exp=%0d conflict=%0d",
                     got.negative, got.d1, got.d2, got.d3, got.d4, got.points,
                     $signed(got.expo), got.conflict);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycles);
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_link.valid = 1'b0;
    in_link.rx_byte = '0;
    out_link.ready = 1'b0;
    shadow_count = '0;
    shadow_bad = 1'b0;
    for (int k = 0; k < 8; k++) shadow_frame[k] = '0;
    set_pacing(0, 0);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_extreme_frames();
    test_sticky_error();
    test_past_last_position();
    test_counter_saturation();

    set_pacing(0, 0);
    test_random_traffic(170);
    set_pacing(69, 0);
    test_random_traffic(170);
    set_pacing(0, 69);
    test_random_traffic(170);
    set_pacing(7, 7);
    test_random_traffic(170);
    in_link.valid <= 1'b0;

    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d display words sent, %0d readings checked, %0d mismatches",
             bytes_sent, readings_seen, mismatches);
    $display("tb: covered extreme, broken and saturated frames under four pacing mixes");
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
